/* rtl/apq_pkg.sv */
// Package for the array priority queue.
// Holds operation and status codes and the compare unit control group.
// No dependencies.
package apq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 4;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_OLD = 2'd1,
        OP_DEQ_MAX = 2'd2,
        OP_DEQ_MIN = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic first;
        logic want_max;
    } t_scan_ctl;

endpackage

/* rtl/apq_mem.sv */
// Entry store of the array priority queue: one write port, one read port,
// registered read data. Depends on apq_pkg.
module apq_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [apq_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [apq_pkg::DATA_W-1:0] o_rdata
);
    import apq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/apq_scan.sv */
// Shared signed compare unit: tracks the best entry seen during a scan.
// Depends on apq_pkg.
module apq_scan #(
    parameter int unsigned AW = 3
) (
    input  logic                       i_clk,
    input  apq_pkg::t_scan_ctl         i_ctl,
    input  logic [AW-1:0]              i_idx,
    input  logic [apq_pkg::DATA_W-1:0] i_data,
    output logic [AW-1:0]              o_best_idx,
    output logic [apq_pkg::DATA_W-1:0] o_best_val
);
    import apq_pkg::*;

    logic [AW-1:0]     r_best_idx;
    logic [DATA_W-1:0] r_best_val;
    logic              better;

    always_comb begin
        if (i_ctl.want_max) begin
            better = $signed(i_data) > $signed(r_best_val);
        end else begin
            better = $signed(i_data) < $signed(r_best_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.first || better)) begin
            r_best_idx <= i_idx;
            r_best_val <= i_data;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_val = r_best_val;

endmodule

/* rtl/array_priority_queue_min_max.sv */
// Top level of the array priority queue: sequencer, entry count and output register.
// Depends on apq_pkg, apq_mem and apq_scan.
//
// Channel | Dir | Bits
// s_axis  | in  | tuser[1:0] opcode; tdata[31:0] value_in
// m_axis  | out | tuser[1:0] status; tdata[31:0] value_out, [35:32] count_out
//
// Enqueue and error results pass through the finish state to the output register.
// A removal scans n entries with the one compare unit (n = count, or 1 for oldest), then
// shifts the later entries down through the single RAM port pair, then passes through the
// finish state to the output register.
// Reset is synchronous, active low, and empties the queue.
// A stalled output holds the sequencer in its last state; s_axis_tready is low while busy.
module array_priority_queue_min_max #(
    parameter int unsigned DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_in
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value_out, count_out, zero fill
    output logic [1:0]  m_axis_tuser    // status
);
    import apq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_scan_len, n_scan_len;
    logic [AW-1:0]         r_widx, n_widx;
    logic                  r_pend, n_pend;
    logic                  r_want_max, n_want_max;
    t_status               r_status, n_status;
    logic [DATA_W-1:0]     r_value, n_value;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_W-1:0]     r_out_value, n_out_value;
    t_status               r_out_status, n_out_status;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_W-1:0]     mem_rdata;
    t_scan_ctl             scan_ctl;
    logic [AW-1:0]         best_idx;
    logic [DATA_W-1:0]     best_val;
    logic [CW+COUNT_W-1:0] count_ext;
    t_opcode               in_op;

    assign in_op         = t_opcode'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign count_ext     = {{COUNT_W{1'b0}}, r_count};

    apq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    apq_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_idx      (r_widx),
        .i_data     (mem_rdata),
        .o_best_idx (best_idx),
        .o_best_val (best_val)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_scan_len   = r_scan_len;
        n_widx       = r_widx;
        n_pend       = r_pend;
        n_want_max   = r_want_max;
        n_status     = r_status;
        n_value      = r_value;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_widx;
        mem_wdata    = mem_rdata;
        mem_raddr    = r_idx[AW-1:0];
        scan_ctl     = '{load: 1'b0, first: 1'b0, want_max: r_want_max};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_want_max = (in_op == OP_DEQ_MAX);
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_value    = '0;
                    n_status   = ST_OK;
                    n_state    = S_FINISH;
                    if (in_op == OP_ENQ) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = s_axis_tdata;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_scan_len = (in_op == OP_DEQ_OLD) ? CW'(1) : r_count;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                scan_ctl.load  = r_pend;
                scan_ctl.first = (r_widx == '0);
                if (r_idx < r_scan_len) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                    n_widx = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_idx == r_scan_len && !r_pend) begin
                    n_idx   = CW'(best_idx) + CW'(1);
                    n_widx  = best_idx;
                    n_value = best_val;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_widx;
                    mem_wdata = mem_rdata;
                    n_widx    = r_widx + AW'(1);
                end
                if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_idx >= r_count && !r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_value;
                    n_out_status = r_status;
                    n_out_count  = count_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_len   <= n_scan_len;
        r_widx       <= n_widx;
        r_want_max   <= n_want_max;
        r_status     <= n_status;
        r_value      <= n_value;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_count, r_out_value};
    assign m_axis_tuser  = r_out_status;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_empty_report : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && s_axis_tvalid && in_op != OP_ENQ && r_count == '0)
        |=> (r_state == S_FINISH && r_status == ST_EMPTY))
        else $error("removal from empty queue not reported");

    a_full_report : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with free slots");

    a_shift_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count != '0 && r_idx <= r_count))
        else $error("shift pointer out of range");

    a_scan_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_scan_len && r_scan_len <= r_count))
        else $error("scan pointer out of range");

endmodule

/* test/array_priority_queue_min_max_checker.sv */
// Checker for the array priority queue: watches both stream channels and predicts each result.
// Depends on apq_pkg for the opcode and status codes.
// Hands its mismatch count and the number of outstanding results to the testbench top.
module array_priority_queue_min_max_checker #(
    parameter int unsigned DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_in
    input  logic [1:0]  s_axis_tuser,   // opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // value_out, count_out, zero fill
    input  logic [1:0]  m_axis_tuser,   // status
    output int          o_fail_count,
    output int          o_pending
);
    import apq_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic [3:0]  count;
    } t_removal;

    logic signed [31:0] slots [DEPTH];
    int unsigned        held;
    t_removal           due_results[$];
    t_removal           want;
    t_removal           got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held         = 0;
    end

    task automatic queue_step(input t_opcode op, input logic signed [31:0] v,
                              output t_removal r);
        int unsigned pos;
        r.value  = '0;
        r.status = ST_OK;
        if (op == OP_ENQ) begin
            if (held >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                slots[held] = v;
                held++;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            pos = 0;
            if (op != OP_DEQ_OLD) begin
                for (int unsigned i = 1; i < held; i++) begin
                    if (op == OP_DEQ_MAX ? slots[i] > slots[pos] : slots[i] < slots[pos])
                        pos = i;
                end
            end
            r.value = slots[pos];
            for (int unsigned i = pos; i + 1 < held; i++)
                slots[i] = slots[i + 1];
            held--;
        end
        r.count = held[3:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            due_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[31:0];
                got.status = t_status'(m_axis_tuser);
                got.count  = m_axis_tdata[35:32];
                if (due_results.size() == 0) begin
                    $error("result with no transaction outstanding: value_out %0d status %0d",
                           $signed(got.value), got.status);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.value !== want.value) begin
                        $error("value_out mismatch: expected %0d, actual %0d",
                               $signed(want.value), $signed(got.value));
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("count_out mismatch: expected %0d, actual %0d",
                               want.count, got.count);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                queue_step(t_opcode'(s_axis_tuser), s_axis_tdata, want);
                due_results.push_back(want);
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* test/array_priority_queue_min_max_tb.sv */
// Testbench top for the array priority queue: clock, reset, stream stimulus and verdict.
// Depends on apq_pkg, the block and array_priority_queue_min_max_checker.
module array_priority_queue_min_max_tb;
    import apq_pkg::*;

    localparam int unsigned DEPTH       = 8;
    localparam int unsigned ITEMS       = 1850;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          fail_count;
    int          pending;
    int unsigned idle_cycles = 0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;

    always #1 i_clk = ~i_clk;

    array_priority_queue_min_max #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    array_priority_queue_min_max_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("array_priority_queue_min_max_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_opcode op, input logic [31:0] v);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(11);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(6) - 3;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_opcode pick_op(input int unsigned enq_pct);
        if ($urandom_range(99) < enq_pct)
            return OP_ENQ;
        return t_opcode'($urandom_range(3, 1));
    endfunction

    initial begin
        int unsigned enq_pct;
        enq_pct        = 50;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ENQ;
        m_axis_tready <= 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_DEQ_OLD, 32'h0000_0000);
        send_item(OP_DEQ_MAX, 32'hffff_ffff);
        send_item(OP_DEQ_MIN, 32'h5555_aaaa);
        send_item(OP_ENQ, 32'h7fff_ffff);
        send_item(OP_ENQ, 32'h8000_0000);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'hffff_ffff);
        send_item(OP_ENQ, 32'd5);
        send_item(OP_ENQ, 32'd5);
        send_item(OP_ENQ, 32'h8000_0000);
        send_item(OP_ENQ, 32'h7fff_ffff);
        send_item(OP_ENQ, 32'd1);
        send_item(OP_DEQ_MAX, 32'h0);
        send_item(OP_DEQ_MIN, 32'h0);
        send_item(OP_DEQ_OLD, 32'h0);
        send_item(OP_DEQ_MAX, 32'h0);
        send_item(OP_DEQ_MIN, 32'h0);
        send_item(OP_DEQ_MAX, 32'h0);
        send_item(OP_DEQ_MIN, 32'h0);
        send_item(OP_DEQ_OLD, 32'h0);
        send_item(OP_DEQ_MAX, 32'haaaa_5555);
        drain_results();

        for (int unsigned n = 0; n < ITEMS; n++) begin
            if (n % 50 == 0) begin
                send_burst = ($urandom_range(3) == 0);
                enq_pct    = 25 + 25 * $urandom_range(2);
            end
            if (n % 400 == 399)
                drain_results();
            send_item(pick_op(enq_pct), pick_value());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("array_priority_queue_min_max_tb passed");
        else
            $display("array_priority_queue_min_max_tb failed");
        $finish;
    end

    initial begin : receive
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        wait (i_rst_n);
        forever begin
            if (taken % 40 == 0)
                recv_burst = ($urandom_range(3) == 0);
            gap = recv_burst ? 0 : $urandom_range(11);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            taken++;
        end
    end

endmodule

/* files.f */
rtl/apq_pkg.sv
rtl/apq_mem.sv
rtl/apq_scan.sv
rtl/array_priority_queue_min_max.sv
test/array_priority_queue_min_max_checker.sv
test/array_priority_queue_min_max_tb.sv
